// File: rtl/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg
// Shared types and constants for the link connect supervisor: phase codes,
// register indexes, and the structs passed between the modules.
// ----------------------------------------------------------------------------
package lcs_pkg;

    localparam int TimeW   = 32;
    localparam int AddrW   = 32;
    localparam int SignalW = 8;
    localparam int PhaseW  = 3;
    localparam int CfgIdxW = 2;

    // phase codes
    localparam logic [PhaseW-1:0] PH_IDLE       = 3'd0;
    localparam logic [PhaseW-1:0] PH_CONNECTING = 3'd1;
    localparam logic [PhaseW-1:0] PH_AWAIT_ADDR = 3'd2;
    localparam logic [PhaseW-1:0] PH_CONNECTED  = 3'd3;
    localparam logic [PhaseW-1:0] PH_BACKOFF    = 3'd4;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_POLL_INTERVAL   = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_CONNECT_TIMEOUT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_ADDRESS_TIMEOUT = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_RETRY_INTERVAL  = 2'd3;

    localparam logic [TimeW-1:0] POLL_INTERVAL_RST   = 32'd500;
    localparam logic [TimeW-1:0] CONNECT_TIMEOUT_RST = 32'd15000;
    localparam logic [TimeW-1:0] ADDRESS_TIMEOUT_RST = 32'd10000;
    localparam logic [TimeW-1:0] RETRY_INTERVAL_RST  = 32'd30000;

    // unbound address 0.0.0.0
    localparam logic [AddrW-1:0] ADDR_UNBOUND = '0;

    typedef struct packed {
        logic [TimeW-1:0] poll_interval;
        logic [TimeW-1:0] connect_timeout;
        logic [TimeW-1:0] address_timeout;
        logic [TimeW-1:0] retry_interval;
    } cfg_t;

    typedef struct packed {
        logic [TimeW-1:0]          now_ms;
        logic                      suspended;
        logic                      reconnect_allowed;
        logic                      link_up;
        logic [AddrW-1:0]          current_address;
        logic signed [SignalW-1:0] signal_sample;
    } tick_t;

    typedef struct packed {
        logic [PhaseW-1:0]         phase;
        logic [TimeW-1:0]          phase_start;
        logic [TimeW-1:0]          last_poll;
        logic [AddrW-1:0]          address;
        logic signed [SignalW-1:0] signal;
    } state_t;

    typedef struct packed {
        logic [PhaseW-1:0]         phase;
        logic                      start_attempt;
        logic                      became_connected;
        logic [AddrW-1:0]          held_address;
        logic signed [SignalW-1:0] held_signal;
    } result_t;

endpackage

// File: rtl/lcs_cfg_regs.sv
// ----------------------------------------------------------------------------
// lcs_cfg_regs
// Timing configuration registers, written through a simple write port.
// ----------------------------------------------------------------------------
module lcs_cfg_regs
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [lcs_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [lcs_pkg::TimeW-1:0]    cfg_data,
    output lcs_pkg::cfg_t                cfg
);
    import lcs_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.poll_interval   <= POLL_INTERVAL_RST;
            cfg_reg.connect_timeout <= CONNECT_TIMEOUT_RST;
            cfg_reg.address_timeout <= ADDRESS_TIMEOUT_RST;
            cfg_reg.retry_interval  <= RETRY_INTERVAL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_POLL_INTERVAL:   cfg_reg.poll_interval   <= cfg_data;
                CFG_CONNECT_TIMEOUT: cfg_reg.connect_timeout <= cfg_data;
                CFG_ADDRESS_TIMEOUT: cfg_reg.address_timeout <= cfg_data;
                CFG_RETRY_INTERVAL:  cfg_reg.retry_interval  <= cfg_data;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/lcs_step.sv
// ----------------------------------------------------------------------------
// lcs_step
// Combinational phase update for one tick: poll rate limiting, timeouts on
// wrap-around time differences, address/signal capture and result pulses.
// ----------------------------------------------------------------------------
module lcs_step
(
    input  lcs_pkg::cfg_t    cfg,
    input  lcs_pkg::tick_t   tick,
    input  lcs_pkg::state_t  st,
    output lcs_pkg::state_t  st_next,
    output lcs_pkg::result_t res
);
    import lcs_pkg::*;

    logic             polled;
    logic             due;
    logic [TimeW-1:0] since_poll;
    logic [TimeW-1:0] elapsed;
    logic             started;
    logic             connected;

    // differences are modulo 2^32 so wrap of now_ms is harmless
    assign since_poll = tick.now_ms - st.last_poll;
    assign elapsed    = tick.now_ms - st.phase_start;
    assign due        = (since_poll >= cfg.poll_interval);
    assign polled     = (st.phase == PH_CONNECTING) || (st.phase == PH_AWAIT_ADDR)
                     || (st.phase == PH_CONNECTED);

    always_comb
    begin
        st_next   = st;
        started   = 1'b0;
        connected = 1'b0;
        if (!tick.suspended)
        begin
            if (polled && due)
                st_next.last_poll = tick.now_ms;

            unique case (st.phase)
                PH_IDLE:
                begin
                    if (tick.reconnect_allowed)
                    begin
                        st_next.phase       = PH_CONNECTING;
                        st_next.phase_start = tick.now_ms;
                        st_next.last_poll   = tick.now_ms;
                        started             = 1'b1;
                    end
                end
                PH_CONNECTING:
                begin
                    if (due)
                    begin
                        if (tick.link_up)
                        begin
                            st_next.phase       = PH_AWAIT_ADDR;
                            st_next.phase_start = tick.now_ms;
                        end
                        else if (elapsed >= cfg.connect_timeout)
                        begin
                            st_next.phase       = PH_BACKOFF;
                            st_next.phase_start = tick.now_ms;
                        end
                    end
                end
                PH_AWAIT_ADDR:
                begin
                    if (due)
                    begin
                        if (!tick.link_up)
                        begin
                            st_next.phase       = PH_BACKOFF;
                            st_next.phase_start = tick.now_ms;
                        end
                        else
                        begin
                            st_next.address = tick.current_address;
                            st_next.signal  = tick.signal_sample;
                            if (tick.current_address != ADDR_UNBOUND)
                            begin
                                st_next.phase       = PH_CONNECTED;
                                st_next.phase_start = tick.now_ms;
                                connected           = 1'b1;
                            end
                            else if (elapsed >= cfg.address_timeout)
                            begin
                                st_next.phase       = PH_BACKOFF;
                                st_next.phase_start = tick.now_ms;
                            end
                        end
                    end
                end
                PH_CONNECTED:
                begin
                    if (due)
                    begin
                        if (!tick.link_up)
                        begin
                            st_next.address     = ADDR_UNBOUND;
                            st_next.signal      = '0;
                            st_next.phase       = PH_BACKOFF;
                            st_next.phase_start = tick.now_ms;
                        end
                        else
                        begin
                            st_next.signal = tick.signal_sample;
                        end
                    end
                end
                PH_BACKOFF:
                begin
                    if ((elapsed >= cfg.retry_interval) && tick.reconnect_allowed)
                    begin
                        st_next.phase       = PH_CONNECTING;
                        st_next.phase_start = tick.now_ms;
                        st_next.last_poll   = tick.now_ms;
                        started             = 1'b1;
                    end
                end
                default:
                begin
                    // unreachable codes: tick has no effect
                    st_next = st;
                end
            endcase
        end
    end

    always_comb
    begin
        res.phase            = st_next.phase;
        res.start_attempt    = started;
        res.became_connected = connected;
        res.held_address     = st_next.address;
        res.held_signal      = st_next.signal;
    end

endmodule

// File: rtl/link_connect_supervisor.sv
// ----------------------------------------------------------------------------
// link_connect_supervisor
// Radio link connection supervisor: one result per tick.
// ----------------------------------------------------------------------------
// Each accepted tick produces exactly one result. A tick is captured in an
// input register, evaluated combinationally against the supervisor state and
// written to the result register while the state is updated. A new tick is
// taken every cycle as long as results are drained (one subtract/compare
// level per timer sets the cycle time). Configuration writes take effect on
// the next clock and are meant for when no tick is in flight.
module link_connect_supervisor
(
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_we,
    input  logic [lcs_pkg::CfgIdxW-1:0]         cfg_index,
    input  logic [lcs_pkg::TimeW-1:0]           cfg_data,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [lcs_pkg::TimeW-1:0]           now_ms,
    input  logic                                suspended,
    input  logic                                reconnect_allowed,
    input  logic                                link_up,
    input  logic [lcs_pkg::AddrW-1:0]           current_address,
    input  logic signed [lcs_pkg::SignalW-1:0]  signal_sample,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [lcs_pkg::PhaseW-1:0]          phase,
    output logic                                start_attempt,
    output logic                                became_connected,
    output logic [lcs_pkg::AddrW-1:0]           held_address,
    output logic signed [lcs_pkg::SignalW-1:0]  held_signal
);
    import lcs_pkg::*;

    cfg_t    cfg;
    tick_t   tick_reg;
    logic    tick_vld_reg;
    state_t  st_reg;
    state_t  st_next;
    result_t res_next;
    result_t res_reg;
    logic    res_vld_reg;
    logic    advance;

    lcs_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lcs_step u_step
    (
        .cfg     (cfg),
        .tick    (tick_reg),
        .st      (st_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    // the held tick moves on whenever the result register is free or draining
    assign advance  = tick_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready = !tick_vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_vld_reg <= 1'b0;
        else if (in_ready)
            tick_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            tick_reg.now_ms            <= now_ms;
            tick_reg.suspended         <= suspended;
            tick_reg.reconnect_allowed <= reconnect_allowed;
            tick_reg.link_up           <= link_up;
            tick_reg.current_address   <= current_address;
            tick_reg.signal_sample     <= signal_sample;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.phase       <= PH_IDLE;
            st_reg.phase_start <= '0;
            st_reg.last_poll   <= '0;
            st_reg.address     <= ADDR_UNBOUND;
            st_reg.signal      <= '0;
        end
        else if (advance)
        begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_vld_reg <= 1'b0;
        else if (advance)
            res_vld_reg <= 1'b1;
        else if (out_ready)
            res_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign out_valid        = res_vld_reg;
    assign phase            = res_reg.phase;
    assign start_attempt    = res_reg.start_attempt;
    assign became_connected = res_reg.became_connected;
    assign held_address     = res_reg.held_address;
    assign held_signal      = res_reg.held_signal;

    // a new attempt always lands in the connecting phase
    a_start_phase: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && start_attempt |-> phase == PH_CONNECTING)
        else $error("start_attempt without connecting phase");

    // connected pulse comes with a bound address
    a_conn_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && became_connected |-> (phase == PH_CONNECTED)
            && (held_address != ADDR_UNBOUND))
        else $error("became_connected without bound address");

    // the two pulses never coincide
    a_pulse_excl: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(start_attempt && became_connected))
        else $error("start_attempt and became_connected together");

    // a tick moved into the result register is presented next cycle
    a_adv_valid: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("result lost after advance");

    // state mirrors the most recent result
    a_state_match: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (st_reg.phase == phase) && (st_reg.address == held_address))
        else $error("state and result disagree");

endmodule

// File: tb/sv/link_connect_supervisor_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// link_connect_supervisor_tb
// Self-checking bench for the radio link connect supervisor.
// ----------------------------------------------------------------------------
// A directed table walks the phases: suspend, attempt start, poll rate limit,
// address capture, loss, backoff, timeouts and a time wrap. Random ticks then
// run under several register settings (zeros, all ones, reset values, small
// and random) with the sender and receiver idling at different rates. Every
// result is checked against its expected table value or an in-bench model of the supervisor.
// ----------------------------------------------------------------------------
module link_connect_supervisor_tb;
    import lcs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_TICKS    = 230;

    typedef struct {
        tick_t   item;
        bit      typed;
        result_t want;
    } plan_row_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [CfgIdxW-1:0]         cfg_index = '0;
    logic [TimeW-1:0]           cfg_data = '0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic [TimeW-1:0]           now_ms = '0;
    logic                       suspended = 1'b0;
    logic                       reconnect_allowed = 1'b0;
    logic                       link_up = 1'b0;
    logic [AddrW-1:0]           current_address = '0;
    logic signed [SignalW-1:0]  signal_sample = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [PhaseW-1:0]          phase;
    logic                       start_attempt;
    logic                       became_connected;
    logic [AddrW-1:0]           held_address;
    logic signed [SignalW-1:0]  held_signal;

    // supervisor model state and register copies
    logic [PhaseW-1:0]          sup_phase;
    logic [TimeW-1:0]           sup_phase_start;
    logic [TimeW-1:0]           sup_last_poll;
    logic [AddrW-1:0]           sup_addr;
    logic signed [SignalW-1:0]  sup_signal;
    logic [TimeW-1:0]           lim_poll;
    logic [TimeW-1:0]           lim_connect;
    logic [TimeW-1:0]           lim_address;
    logic [TimeW-1:0]           lim_retry;

    result_t                    pending_results[$];
    plan_row_t                  plan[$];
    int                         mismatches = 0;
    int                         results_seen = 0;
    int                         quiet_cycles = 0;
    int                         idle_mode = 0;

    link_connect_supervisor dut (.*);

    always #5 clk = ~clk;

    function automatic result_t next_link_result(input tick_t t);
        result_t     r;
        logic        polled;
        logic        due;
        logic [31:0] since_poll;
        logic [31:0] elapsed;
        r = '0;
        if (!t.suspended)
        begin
            polled = (sup_phase == PH_CONNECTING) || (sup_phase == PH_AWAIT_ADDR)
                     || (sup_phase == PH_CONNECTED);
            since_poll = t.now_ms - sup_last_poll;
            elapsed = t.now_ms - sup_phase_start;
            due = since_poll >= lim_poll;
            if (polled && due)
                sup_last_poll = t.now_ms;
            case (sup_phase)
                PH_IDLE:
                begin
                    if (t.reconnect_allowed)
                    begin
                        sup_phase = PH_CONNECTING;
                        sup_phase_start = t.now_ms;
                        sup_last_poll = t.now_ms;
                        r.start_attempt = 1'b1;
                    end
                end
                PH_CONNECTING:
                begin
                    if (due && t.link_up)
                    begin
                        sup_phase = PH_AWAIT_ADDR;
                        sup_phase_start = t.now_ms;
                    end
                    else if (due && elapsed >= lim_connect)
                    begin
                        sup_phase = PH_BACKOFF;
                        sup_phase_start = t.now_ms;
                    end
                end
                PH_AWAIT_ADDR:
                begin
                    if (due && !t.link_up)
                    begin
                        sup_phase = PH_BACKOFF;
                        sup_phase_start = t.now_ms;
                    end
                    else if (due)
                    begin
                        sup_addr = t.current_address;
                        sup_signal = t.signal_sample;
                        if (sup_addr != ADDR_UNBOUND)
                        begin
                            sup_phase = PH_CONNECTED;
                            sup_phase_start = t.now_ms;
                            r.became_connected = 1'b1;
                        end
                        else if (elapsed >= lim_address)
                        begin
                            sup_phase = PH_BACKOFF;
                            sup_phase_start = t.now_ms;
                        end
                    end
                end
                PH_CONNECTED:
                begin
                    if (due && !t.link_up)
                    begin
                        sup_addr = ADDR_UNBOUND;
                        sup_signal = '0;
                        sup_phase = PH_BACKOFF;
                        sup_phase_start = t.now_ms;
                    end
                    else if (due)
                        sup_signal = t.signal_sample;
                end
                PH_BACKOFF:
                begin
                    if (elapsed >= lim_retry && t.reconnect_allowed)
                    begin
                        sup_phase = PH_CONNECTING;
                        sup_phase_start = t.now_ms;
                        sup_last_poll = t.now_ms;
                        r.start_attempt = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.phase = sup_phase;
        r.held_address = sup_addr;
        r.held_signal = sup_signal;
        return r;
    endfunction

    function automatic plan_row_t plan_tick(input logic [31:0] t_now, input bit s, input bit a,
                                            input bit u, input logic [31:0] addr,
                                            input logic signed [7:0] sig, input bit typed,
                                            input logic [PhaseW-1:0] ph, input bit st,
                                            input bit bc, input logic [31:0] ha,
                                            input logic signed [7:0] hs);
        plan_row_t row;
        row.item = '{now_ms: t_now, suspended: s, reconnect_allowed: a, link_up: u,
                     current_address: addr, signal_sample: sig};
        row.typed = typed;
        row.want = '{phase: ph, start_attempt: st, became_connected: bc,
                     held_address: ha, held_signal: hs};
        return row;
    endfunction

    // called right after a rising edge; returns at the edge of the transfer
    task automatic push_tick(input tick_t t, input bit typed, input result_t want);
        result_t predicted;
        while ((idle_mode == 1 && $urandom_range(0, 99) < 74)
               || (idle_mode == 3 && $urandom_range(0, 99) < 20))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        now_ms <= t.now_ms;
        suspended <= t.suspended;
        reconnect_allowed <= t.reconnect_allowed;
        link_up <= t.link_up;
        current_address <= t.current_address;
        signal_sample <= t.signal_sample;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = next_link_result(t);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_limits(input logic [31:0] p, input logic [31:0] c,
                                input logic [31:0] a, input logic [31:0] r);
        logic [CfgIdxW-1:0] idx[4];
        logic [31:0]        val[4];
        idx = '{CFG_POLL_INTERVAL, CFG_CONNECT_TIMEOUT, CFG_ADDRESS_TIMEOUT,
                CFG_RETRY_INTERVAL};
        val = '{p, c, a, r};
        for (int i = 0; i < 4; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        lim_poll = p;
        lim_connect = c;
        lim_address = a;
        lim_retry = r;
        @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        out_ready <= !((idle_mode == 2 && $urandom_range(0, 99) < 74)
                       || (idle_mode == 3 && $urandom_range(0, 99) < 20));
    end

    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{phase: phase, start_attempt: start_attempt,
                    became_connected: became_connected, held_address: held_address,
                    held_signal: held_signal};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d with no tick pending: phase=%0d addr=%h sig=%0d",
                             results_seen, got.phase, got.held_address, got.held_signal);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.phase != want.phase || got.start_attempt != want.start_attempt
                    || got.became_connected != want.became_connected
                    || got.held_address != want.held_address
                    || got.held_signal != want.held_signal)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("result %0d: expected phase=%0d start=%0b conn=%0b %s",
                                 results_seen, want.phase, want.start_attempt,
                                 want.became_connected, "");
                        $display("    expected addr=%h sig=%0d", want.held_address,
                                 want.held_signal);
                        $display("    got phase=%0d start=%0b conn=%0b addr=%h sig=%0d",
                                 got.phase, got.start_attempt, got.became_connected,
                                 got.held_address, got.held_signal);
                    end
                end
            end
            results_seen++;
        end
    end

    // ends the run when no transfer happens for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("link_connect_supervisor: mismatch");
            $finish;
        end
    end

    initial
    begin
        tick_t       t;
        logic [31:0] t_now;
        logic [31:0] step;
        bit          link_state;
        bit          noise;
        int          pick;

        sup_phase = PH_IDLE;
        sup_phase_start = '0;
        sup_last_poll = '0;
        sup_addr = ADDR_UNBOUND;
        sup_signal = '0;
        lim_poll = POLL_INTERVAL_RST;
        lim_connect = CONNECT_TIMEOUT_RST;
        lim_address = ADDRESS_TIMEOUT_RST;
        lim_retry = RETRY_INTERVAL_RST;
        link_state = 1'b0;
        t_now = '0;

        // directed walk at the reset register values
        plan.push_back(plan_tick(32'd0, 1, 1, 0, 32'd0, 8'sd0, 1, PH_IDLE, 0, 0, 32'd0, 8'sd0));
        plan.push_back(plan_tick(32'd100, 0, 0, 0, 32'd0, 8'sd0, 1, PH_IDLE, 0, 0, 32'd0, 8'sd0));
        plan.push_back(plan_tick(32'd200, 0, 1, 0, 32'd0, 8'sd0,
                                 1, PH_CONNECTING, 1, 0, 32'd0, 8'sd0));
        plan.push_back(plan_tick(32'd300, 0, 1, 1, 32'd0, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));
        plan.push_back(plan_tick(32'd700, 0, 1, 1, 32'd0, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));
        plan.push_back(plan_tick(32'd1200, 0, 1, 1, 32'd0, -8'sd128, 0, PH_IDLE, 0, 0, 0, 0));
        plan.push_back(plan_tick(32'd1700, 0, 1, 1, 32'hFFFF_FFFF, 8'sd0,
                                 1, PH_CONNECTED, 0, 1, 32'hFFFF_FFFF, 8'sd0));
        plan.push_back(plan_tick(32'd2200, 1, 1, 0, 32'd0, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));
        // positive signal is held as its raw pattern
        plan.push_back(plan_tick(32'd2200, 0, 1, 1, 32'd5, 8'sd127, 0, PH_IDLE, 0, 0, 0, 0));
        plan.push_back(plan_tick(32'd2700, 0, 1, 0, 32'd5, 8'sd0,
                                 1, PH_BACKOFF, 0, 0, 32'd0, 8'sd0));
        plan.push_back(plan_tick(32'd2800, 0, 1, 0, 32'd0, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));
        plan.push_back(plan_tick(32'd32700, 0, 0, 0, 32'd0, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));
        plan.push_back(plan_tick(32'd32700, 0, 1, 0, 32'd0, 8'sd0,
                                 1, PH_CONNECTING, 1, 0, 32'd0, 8'sd0));
        plan.push_back(plan_tick(32'd47700, 0, 1, 0, 32'd0, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));
        // attempt just below the wrap, poll just after it
        plan.push_back(plan_tick(32'hFFFF_FFF0, 0, 1, 0, 32'd0, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));
        plan.push_back(plan_tick(32'd484, 0, 1, 1, 32'd0, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));
        plan.push_back(plan_tick(32'd980, 0, 1, 1, 32'd9, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));
        plan.push_back(plan_tick(32'd996, 0, 1, 0, 32'd9, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));
        plan.push_back(plan_tick(32'd30996, 0, 1, 0, 32'd0, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));
        plan.push_back(plan_tick(32'd31496, 0, 1, 1, 32'd0, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));
        // address never bound: timeout into backoff
        plan.push_back(plan_tick(32'd41496, 0, 1, 1, 32'd0, -8'sd7, 0, PH_IDLE, 0, 0, 0, 0));
        plan.push_back(plan_tick(32'd80000, 1, 1, 1, 32'd3, 8'sd0, 0, PH_IDLE, 0, 0, 0, 0));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            push_tick(plan[i].item, plan[i].typed, plan[i].want);

        for (int p = 0; p < 8; p++)
        begin
            drain_results();
            case (p)
                0: write_limits('0, '0, '0, '0);
                1: write_limits($urandom_range(0, 600), $urandom_range(0, 3000),
                                $urandom_range(0, 3000), $urandom_range(0, 5000));
                2: write_limits('1, '1, '1, '1);
                3: write_limits(POLL_INTERVAL_RST, CONNECT_TIMEOUT_RST,
                                ADDRESS_TIMEOUT_RST, RETRY_INTERVAL_RST);
                4: write_limits(32'd1, $urandom_range(0, 2000), $urandom_range(0, 2000),
                                $urandom_range(0, 2000));
                5: write_limits($urandom, $urandom, $urandom, $urandom);
                6: write_limits($urandom_range(0, 300), $urandom_range(0, 1500),
                                $urandom_range(0, 1500), $urandom_range(0, 3000));
                default: write_limits('0, $urandom_range(1, 2000), $urandom_range(1, 2000),
                                      $urandom_range(1, 2000));
            endcase
            idle_mode = p % 4;
            for (int n = 0; n < PHASE_TICKS; n++)
            begin
                // sender holds off until the block has fully drained
                if (p == 3 && n == PHASE_TICKS / 2)
                    drain_results();
                pick = $urandom_range(0, 9);
                case (pick)
                    0: step = '0;
                    1, 2, 3: step = $urandom_range(0, 700);
                    4: step = lim_poll - 1 + $urandom_range(0, 2);
                    5: step = lim_connect - 1 + $urandom_range(0, 2);
                    6: step = lim_address - 1 + $urandom_range(0, 2);
                    7: step = lim_retry - 1 + $urandom_range(0, 2);
                    8: step = $urandom;
                    default: step = 32'hFFFF_FFFF;
                endcase
                t_now = t_now + step;
                if ($urandom_range(0, 99) < 15)
                    link_state = ~link_state;
                noise = $urandom_range(0, 99) < 8;
                t.now_ms = noise ? $urandom : t_now;
                t.suspended = $urandom_range(0, 99) < 8;
                t.reconnect_allowed = $urandom_range(0, 99) < 80;
                t.link_up = noise ? 1'($urandom_range(0, 1)) : link_state;
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    t.current_address = ADDR_UNBOUND;
                else if (pick == 3)
                    t.current_address = '1;
                else
                    t.current_address = $urandom;
                if ($urandom_range(0, 9) == 0)
                    t.signal_sample = 8'($urandom);
                else
                    t.signal_sample = 8'(0 - int'($urandom_range(0, 128)));
                push_tick(t, 1'b0, '0);
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("link_connect_supervisor: match");
        else
            $display("link_connect_supervisor: mismatch");
        $finish;
    end

endmodule
